@@ design/remgr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// remgr_pkg
// Shared types and constants of the encoder volume, mute and gain ramp block.
// ----------------------------------------------------------------------------
package remgr_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int GAIN_FRAC_BITS = 16;
  localparam int GAIN_W         = GAIN_FRAC_BITS + 1;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = GAIN_W;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W    = QUEUE_PTR_W + 1;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(1) << GAIN_FRAC_BITS;

  localparam logic [7:0] MIDI_LEN_CC     = 8'd3;
  localparam logic [3:0] STATUS_CC_HI    = 4'hB;
  localparam logic [7:0] DATA_CENTER     = 8'd64;
  localparam logic [6:0] VALUE_MAX       = 7'd127;
  localparam logic [6:0] VALUE_MIN       = 7'd0;
  localparam logic [6:0] VOLUME_RESET    = 7'd3;

  localparam logic [3:0]        CHANNEL_RESET = 4'd0;
  localparam logic [6:0]        ENC_CC_RESET  = 7'd114;
  localparam logic [6:0]        BTN_CC_RESET  = 7'd115;
  localparam logic [6:0]        VOL_CC_RESET  = 7'd119;
  localparam logic [6:0]        MUTE_CC_RESET = 7'd118;
  localparam logic [GAIN_W-1:0] STEP_RESET    = GAIN_W'(137);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIDI_CHANNEL  = 3'd0,
    REG_ENCODER_IN_CC = 3'd1,
    REG_BUTTON_IN_CC  = 3'd2,
    REG_VOLUME_OUT_CC = 3'd3,
    REG_MUTE_OUT_CC   = 3'd4,
    REG_RAMP_STEP     = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_ENC    = 2'd1,
    OP_BTN    = 2'd2,
    OP_AUDIO  = 2'd3
  } op_e;

  typedef struct packed {
    logic [3:0]        channel;
    logic [6:0]        enc_cc;
    logic [6:0]        btn_cc;
    logic [6:0]        vol_cc;
    logic [6:0]        mute_cc;
    logic [GAIN_W-1:0] step;
  } cfg_t;

  typedef struct packed {
    op_e                            op;
    logic [7:0]                     data;
    logic signed [SAMPLE_BITS-1:0]  left;
    logic signed [SAMPLE_BITS-1:0]  right;
  } cmd_t;

endpackage

@@ design/remgr_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// remgr_front
// Decodes an incoming MIDI message or audio frame into a queue command.
// ----------------------------------------------------------------------------
module remgr_front (
  input  remgr_pkg::cfg_t                           cfg_i,
  input  logic                                      kind_i,
  input  logic [7:0]                                msg_length_i,
  input  logic [7:0]                                status_byte_i,
  input  logic [7:0]                                controller_byte_i,
  input  logic [7:0]                                data_byte_i,
  input  logic signed [remgr_pkg::SAMPLE_BITS-1:0]  left_in_i,
  input  logic signed [remgr_pkg::SAMPLE_BITS-1:0]  right_in_i,
  output remgr_pkg::cmd_t                           cmd_o
);
  import remgr_pkg::*;

  logic cc_match;
  logic enc_hit;
  logic btn_hit;

  assign cc_match = (msg_length_i == MIDI_LEN_CC) && (status_byte_i[7:4] == STATUS_CC_HI) &&
                    (status_byte_i[3:0] == cfg_i.channel);
  assign enc_hit  = (controller_byte_i == {1'b0, cfg_i.enc_cc});
  assign btn_hit  = (controller_byte_i == {1'b0, cfg_i.btn_cc});

  always_comb begin
    cmd_o.data  = data_byte_i;
    cmd_o.left  = left_in_i;
    cmd_o.right = right_in_i;
    if (kind_i) begin
      cmd_o.op = OP_AUDIO;
    end else if (!cc_match) begin
      cmd_o.op = OP_NONE;
    end else if (enc_hit) begin
      cmd_o.op = (data_byte_i == DATA_CENTER) ? OP_NONE : OP_ENC;
    end else if (btn_hit) begin
      cmd_o.op = OP_BTN;
    end else begin
      cmd_o.op = OP_NONE;
    end
  end

endmodule

@@ design/remgr_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// remgr_queue
// Short command queue between the decode front and the execute back end.
// ----------------------------------------------------------------------------
module remgr_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  remgr_pkg::cmd_t  push_cmd_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output remgr_pkg::cmd_t  pop_cmd_o
);
  import remgr_pkg::*;

  cmd_t                   mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0] cnt_q, cnt_d;
  logic                   do_push;
  logic                   do_pop;

  assign full_o    = (cnt_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_cmd_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + QUEUE_CNT_W'(do_push) - QUEUE_CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QUEUE_CNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q - rd_ptr_q) == cnt_q[QUEUE_PTR_W-1:0])
    else $error("queue pointers disagree with count");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count missed a push");

endmodule

@@ design/remgr_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// remgr_back
// Executes queued commands: volume, mute, gain ramp and sample scaling.
// ----------------------------------------------------------------------------
module remgr_back (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  remgr_pkg::cfg_t                           cfg_i,
  input  logic                                      empty_i,
  input  remgr_pkg::cmd_t                           cmd_i,
  output logic                                      pop_o,
  output logic                                      out_valid_o,
  input  logic                                      out_stall_i,
  output logic                                      msg_valid_o,
  output logic [7:0]                                out_status_o,
  output logic [6:0]                                out_controller_o,
  output logic [6:0]                                out_value_o,
  output logic                                      audio_valid_o,
  output logic signed [remgr_pkg::SAMPLE_BITS-1:0]  left_out_o,
  output logic signed [remgr_pkg::SAMPLE_BITS-1:0]  right_out_o
);
  import remgr_pkg::*;

  localparam int PROD_W = SAMPLE_BITS + GAIN_W + 1;

  logic [6:0]        volume_q, volume_d;
  logic              muted_q, muted_d;
  logic              held_q, held_d;
  logic [GAIN_W-1:0] gain_q, gain_d;

  logic                          s1_valid_q, s1_valid_d;
  logic                          s1_msg_q, s1_msg_d;
  logic [6:0]                    s1_ctl_q, s1_ctl_d;
  logic [6:0]                    s1_value_q, s1_value_d;
  logic                          s1_audio_q, s1_audio_d;
  logic [GAIN_W-1:0]             s1_gain_q, s1_gain_d;
  logic signed [SAMPLE_BITS-1:0] s1_left_q, s1_left_d;
  logic signed [SAMPLE_BITS-1:0] s1_right_q, s1_right_d;

  logic                          out_valid_q;
  logic                          out_msg_q;
  logic [7:0]                    out_status_q;
  logic [6:0]                    out_ctl_q;
  logic [6:0]                    out_value_q;
  logic                          out_audio_q;
  logic signed [SAMPLE_BITS-1:0] out_left_q;
  logic signed [SAMPLE_BITS-1:0] out_right_q;

  logic                          advance;
  logic signed [9:0]             vol_sum;
  logic                          pressed;
  logic [GAIN_W-1:0]             target;
  logic [GAIN_W:0]               gain_up;
  logic [GAIN_W-1:0]             gain_gap;
  logic signed [PROD_W-1:0]      prod_l;
  logic signed [PROD_W-1:0]      prod_r;

  assign advance = !out_valid_q || !out_stall_i;
  assign pop_o   = advance && !empty_i;

  assign vol_sum  = $signed({3'b000, volume_q}) + $signed({2'b00, cmd_i.data}) - 10'sd64;
  assign pressed  = (cmd_i.data >= DATA_CENTER);
  assign target   = muted_q ? '0 : UNITY_GAIN;
  assign gain_up  = {1'b0, gain_q} + {1'b0, cfg_i.step};
  assign gain_gap = gain_q - target;

  always_comb begin
    volume_d   = volume_q;
    muted_d    = muted_q;
    held_d     = held_q;
    gain_d     = gain_q;
    s1_valid_d = pop_o;
    s1_msg_d   = 1'b0;
    s1_ctl_d   = '0;
    s1_value_d = '0;
    s1_audio_d = 1'b0;
    s1_gain_d  = '0;
    s1_left_d  = '0;
    s1_right_d = '0;
    if (pop_o) begin
      unique case (cmd_i.op)
        OP_ENC: begin
          if (vol_sum < 10'sd0) begin
            volume_d = VALUE_MIN;
          end else if (vol_sum > 10'sd127) begin
            volume_d = VALUE_MAX;
          end else begin
            volume_d = vol_sum[6:0];
          end
          s1_msg_d   = 1'b1;
          s1_ctl_d   = cfg_i.vol_cc;
          s1_value_d = volume_d;
        end
        OP_BTN: begin
          held_d = pressed;
          if (pressed && !held_q) begin
            muted_d    = !muted_q;
            s1_msg_d   = 1'b1;
            s1_ctl_d   = cfg_i.mute_cc;
            s1_value_d = muted_d ? VALUE_MAX : VALUE_MIN;
          end
        end
        OP_AUDIO: begin
          if (gain_q < target) begin
            gain_d = (gain_up > {1'b0, target}) ? target : gain_up[GAIN_W-1:0];
          end else if (gain_q > target) begin
            gain_d = (gain_gap <= cfg_i.step) ? target : gain_q - cfg_i.step;
          end
          s1_audio_d = 1'b1;
          s1_gain_d  = gain_d;
          s1_left_d  = cmd_i.left;
          s1_right_d = cmd_i.right;
        end
        default: begin
        end
      endcase
    end
  end

  assign prod_l = PROD_W'(s1_left_q) * $signed({1'b0, s1_gain_q});
  assign prod_r = PROD_W'(s1_right_q) * $signed({1'b0, s1_gain_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volume_q    <= VOLUME_RESET;
      muted_q     <= 1'b0;
      held_q      <= 1'b0;
      gain_q      <= UNITY_GAIN;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      volume_q <= volume_d;
      muted_q  <= muted_d;
      held_q   <= held_d;
      gain_q   <= gain_d;
      if (advance) begin
        s1_valid_q  <= s1_valid_d;
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_msg_q     <= s1_msg_d;
      s1_ctl_q     <= s1_ctl_d;
      s1_value_q   <= s1_value_d;
      s1_audio_q   <= s1_audio_d;
      s1_gain_q    <= s1_gain_d;
      s1_left_q    <= s1_left_d;
      s1_right_q   <= s1_right_d;
      out_msg_q    <= s1_msg_q;
      out_status_q <= s1_msg_q ? {STATUS_CC_HI, cfg_i.channel} : 8'd0;
      out_ctl_q    <= s1_ctl_q;
      out_value_q  <= s1_value_q;
      out_audio_q  <= s1_audio_q;
      out_left_q   <= prod_l[GAIN_FRAC_BITS +: SAMPLE_BITS];
      out_right_q  <= prod_r[GAIN_FRAC_BITS +: SAMPLE_BITS];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign msg_valid_o      = out_msg_q;
  assign out_status_o     = out_status_q;
  assign out_controller_o = out_ctl_q;
  assign out_value_o      = out_value_q;
  assign audio_valid_o    = out_audio_q;
  assign left_out_o       = out_left_q;
  assign right_out_o      = out_right_q;

  a_gain_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gain_q <= UNITY_GAIN)
    else $error("gain above unity");

  a_enc_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && cmd_i.op == OP_ENC) |=> (s1_valid_q && s1_msg_q && !s1_audio_q))
    else $error("encoder command produced no message");

  a_mute_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_o && cmd_i.op == OP_BTN) |=> $stable(muted_q))
    else $error("mute changed without a button command");

  a_gain_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_o && cmd_i.op == OP_AUDIO) |=> $stable(gain_q))
    else $error("gain moved without an audio frame");

endmodule

@@ design/relative_encoder_mute_gain_ramp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relative_encoder_mute_gain_ramp
// Relative encoder volume, mute button and ramped stereo gain.
//
// Input channel (in_valid_i / in_stall_o) carries either a three-byte MIDI
// control change (kind_i low) or one stereo frame (kind_i high). Output
// channel (out_valid_o / out_stall_i) returns exactly one result per input
// item, in order. A transfer happens on a rising edge with valid high and
// stall low.
// One item per cycle is sustained while out_stall_i stays low. A four-entry
// command queue sits between the decoder and the execute pipeline;
// in_stall_o rises only when that queue is full. The execute path has an
// update stage (volume, mute, gain ramp) and a scaling stage (24 x 17 bit
// multiply) that loads the output register. While out_stall_i is high with
// a result valid, the output holds and the back end pauses; the queue keeps
// taking items until it fills. Reset clears the queue and pipeline, and
// loads volume 3, unmuted, unity gain and the default controller numbers
// and ramp step. Configuration writes go through cfg_we_i / cfg_idx_i /
// cfg_wdata_i; the user must make them only while idle; it is not enforced.
// ----------------------------------------------------------------------------
module relative_encoder_mute_gain_ramp (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      cfg_we_i,
  input  logic [remgr_pkg::CFG_IDX_W-1:0]           cfg_idx_i,
  input  logic [remgr_pkg::CFG_DATA_W-1:0]          cfg_wdata_i,
  input  logic                                      in_valid_i,
  output logic                                      in_stall_o,
  input  logic                                      kind_i,
  input  logic [7:0]                                msg_length_i,
  input  logic [7:0]                                status_byte_i,
  input  logic [7:0]                                controller_byte_i,
  input  logic [7:0]                                data_byte_i,
  input  logic signed [remgr_pkg::SAMPLE_BITS-1:0]  left_in_i,
  input  logic signed [remgr_pkg::SAMPLE_BITS-1:0]  right_in_i,
  output logic                                      out_valid_o,
  input  logic                                      out_stall_i,
  output logic                                      msg_valid_o,
  output logic [7:0]                                out_status_o,
  output logic [6:0]                                out_controller_o,
  output logic [6:0]                                out_value_o,
  output logic                                      audio_valid_o,
  output logic signed [remgr_pkg::SAMPLE_BITS-1:0]  left_out_o,
  output logic signed [remgr_pkg::SAMPLE_BITS-1:0]  right_out_o
);
  import remgr_pkg::*;

  cfg_t cfg_q;
  cmd_t front_cmd;
  cmd_t queue_cmd;
  logic queue_full;
  logic queue_empty;
  logic back_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channel <= CHANNEL_RESET;
      cfg_q.enc_cc  <= ENC_CC_RESET;
      cfg_q.btn_cc  <= BTN_CC_RESET;
      cfg_q.vol_cc  <= VOL_CC_RESET;
      cfg_q.mute_cc <= MUTE_CC_RESET;
      cfg_q.step    <= STEP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MIDI_CHANNEL:  cfg_q.channel <= cfg_wdata_i[3:0];
        REG_ENCODER_IN_CC: cfg_q.enc_cc  <= cfg_wdata_i[6:0];
        REG_BUTTON_IN_CC:  cfg_q.btn_cc  <= cfg_wdata_i[6:0];
        REG_VOLUME_OUT_CC: cfg_q.vol_cc  <= cfg_wdata_i[6:0];
        REG_MUTE_OUT_CC:   cfg_q.mute_cc <= cfg_wdata_i[6:0];
        REG_RAMP_STEP:     cfg_q.step    <= cfg_wdata_i[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall_o = queue_full;

  remgr_front u_front (
    .cfg_i             (cfg_q),
    .kind_i            (kind_i),
    .msg_length_i      (msg_length_i),
    .status_byte_i     (status_byte_i),
    .controller_byte_i (controller_byte_i),
    .data_byte_i       (data_byte_i),
    .left_in_i         (left_in_i),
    .right_in_i        (right_in_i),
    .cmd_o             (front_cmd)
  );

  remgr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_valid_i),
    .push_cmd_i (front_cmd),
    .full_o     (queue_full),
    .pop_i      (back_pop),
    .empty_o    (queue_empty),
    .pop_cmd_o  (queue_cmd)
  );

  remgr_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .empty_i          (queue_empty),
    .cmd_i            (queue_cmd),
    .pop_o            (back_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .msg_valid_o      (msg_valid_o),
    .out_status_o     (out_status_o),
    .out_controller_o (out_controller_o),
    .out_value_o      (out_value_o),
    .audio_valid_o    (audio_valid_o),
    .left_out_o       (left_out_o),
    .right_out_o      (right_out_o)
  );

endmodule
